// File: design/edra_pkg.sv
// Shared types and constants for the elevator disk request arbiter.
// Depends on nothing; every other file in the design refers to it by scoped names.
package edra_pkg;

   // Fixed field widths of the transfer payloads
   localparam int OP_W     = 2;
   localparam int CLIENT_W = 4;
   localparam int TRACK_W  = 16;
   localparam int STATUS_W = 3;

   // Input operation codes
   typedef enum logic [OP_W-1:0] {
      OP_REQUEST = 2'd0,
      OP_RELEASE = 2'd1,
      OP_EXPIRE  = 2'd2
   } op_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED = 3'd0,
      ST_QUEUED  = 3'd1,
      ST_WAITER  = 3'd2,
      ST_FREED   = 3'd3,
      ST_REMOVED = 3'd4,
      ST_IGNORED = 3'd5
   } status_type;

   // Controller states
   typedef enum logic {
      CTL_IDLE  = 1'b0,
      CTL_PURGE = 1'b1
   } ctl_state_type;

   // Per-cycle command to a whole cell chain
   typedef enum logic [1:0] {
      CH_HOLD   = 2'd0,
      CH_INSERT = 2'd1,
      CH_POP    = 2'd2,
      CH_PURGE  = 2'd3
   } chain_op_type;

   typedef struct packed {
      chain_op_type          op;
      logic                  expire;
      logic [CLIENT_W-1:0]   client;
   } chain_cmd_type;

   // Flags a cell hands to its right-hand neighbour
   typedef struct packed {
      logic after;   // new entry belongs at or before this cell
      logic seen;    // a purge match exists at or before this cell
   } link_type;

   // Summary a chain reports to the controller
   typedef struct packed {
      logic front_valid;
      logic any_match;
   } chain_status_type;

endpackage

// File: design/edra_req_if.sv
// Request channel of the disk arbiter: valid/ready handshake and the input payload.
// Depends on edra_pkg for field widths.
interface edra_req_if;
   logic                          valid;
   logic                          ready;
   logic [edra_pkg::OP_W-1:0]     operation;
   logic [edra_pkg::CLIENT_W-1:0] requester;
   logic [edra_pkg::TRACK_W-1:0]  track;
   logic                          may_expire;

   modport source (output valid, output operation, output requester, output track,
                   output may_expire, input ready);
   modport sink   (input valid, input operation, input requester, input track,
                   input may_expire, output ready);
endinterface

// File: design/edra_rsp_if.sv
// Result channel of the disk arbiter: valid/ready handshake and the result payload.
// Depends on edra_pkg for field widths.
interface edra_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [edra_pkg::STATUS_W-1:0] status;
   logic [edra_pkg::CLIENT_W-1:0] client;
   logic [edra_pkg::TRACK_W-1:0]  head_track;

   modport source (output valid, output status, output client, output head_track,
                   input ready);
   modport sink   (input valid, input status, input client, input head_track,
                   output ready);
endinterface

// File: design/elevator_disk_request_arbiter.sv
// C-LOOK disk request arbiter. A request, a release or any other code has its result
// ready in the cycle after transfer; an expiry stays in the purge state while either queue
// holds a matching expirable entry, the purge shift in the cell chains removing one
// matching entry per queue per cycle, then loads its result. Each queue is a row of
// QUEUE_DEPTH sorted cells; insert and pop are single parallel shifts. The result sits in
// an output register; outside a purge a new item is taken whenever it is empty or drains.
module elevator_disk_request_arbiter #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TRACK_BITS  = 16
) (
   input  logic       clock,
   input  logic       reset,
   edra_req_if.sink   req_chan,
   edra_rsp_if.source rsp_chan
);

   edra_pkg::ctl_state_type       state_ff, state_in;
   logic                          busy_ff, busy_in;
   logic [TRACK_BITS-1:0]         head_ff, head_in;
   logic                          sel_ff, sel_in;
   logic [edra_pkg::CLIENT_W-1:0] purge_client_ff, purge_client_in;
   logic                          removed_ff, removed_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [edra_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [edra_pkg::CLIENT_W-1:0] rsp_client_ff;
   logic [edra_pkg::TRACK_W-1:0]  rsp_head_ff;

   edra_pkg::chain_cmd_type       cmd_a, cmd_b;
   edra_pkg::chain_status_type    stat_a, stat_b;
   logic [edra_pkg::CLIENT_W-1:0] front_client_a, front_client_b;
   logic [TRACK_BITS-1:0]         front_track_a, front_track_b;
   logic [TRACK_BITS-1:0]         new_track;
   logic                          slot_free;
   logic                          sweep_valid, wrap_valid, to_sweep, into_b;
   logic                          load;
   edra_pkg::status_type          load_status;
   logic [edra_pkg::CLIENT_W-1:0] load_client;

   assign new_track   = TRACK_BITS'(req_chan.track);
   assign slot_free   = !rsp_valid_ff || rsp_chan.ready;
   // sel_ff low: chain A holds the sweep queue
   assign sweep_valid = sel_ff ? stat_b.front_valid : stat_a.front_valid;
   assign wrap_valid  = sel_ff ? stat_a.front_valid : stat_b.front_valid;
   assign to_sweep    = new_track >= head_ff;
   assign into_b      = to_sweep ? sel_ff : !sel_ff;

   edra_chain #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TRACK_BITS  (TRACK_BITS)
   ) u_chain_a (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd_a),
      .new_track    (new_track),
      .status       (stat_a),
      .front_client (front_client_a),
      .front_track  (front_track_a)
   );

   edra_chain #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TRACK_BITS  (TRACK_BITS)
   ) u_chain_b (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd_b),
      .new_track    (new_track),
      .status       (stat_b),
      .front_client (front_client_b),
      .front_track  (front_track_b)
   );

   // Decode the item, steer the chains and form the result
   always_comb begin
      state_in        = state_ff;
      busy_in         = busy_ff;
      head_in         = head_ff;
      sel_in          = sel_ff;
      purge_client_in = purge_client_ff;
      removed_in      = removed_ff;
      cmd_a           = '{op: edra_pkg::CH_HOLD, expire: req_chan.may_expire,
                          client: req_chan.requester};
      cmd_b           = cmd_a;
      load            = 1'b0;
      load_status     = edra_pkg::ST_IGNORED;
      load_client     = req_chan.requester;
      req_chan.ready  = 1'b0;
      case (state_ff)
         edra_pkg::CTL_IDLE: begin
            req_chan.ready = slot_free;
            if (req_chan.valid && slot_free) begin
               case (edra_pkg::op_type'(req_chan.operation))
                  edra_pkg::OP_REQUEST: begin
                     load = 1'b1;
                     if (!busy_ff) begin
                        busy_in     = 1'b1;
                        head_in     = new_track;
                        load_status = edra_pkg::ST_GRANTED;
                     end else begin
                        load_status = edra_pkg::ST_QUEUED;
                        if (into_b) begin
                           cmd_b.op = edra_pkg::CH_INSERT;
                        end else begin
                           cmd_a.op = edra_pkg::CH_INSERT;
                        end
                     end
                  end
                  edra_pkg::OP_RELEASE: begin
                     load = 1'b1;
                     if (sweep_valid || wrap_valid) begin
                        // pop the sweep queue, or swap roles and pop the wrap queue
                        busy_in     = 1'b1;
                        load_status = edra_pkg::ST_WAITER;
                        if (sweep_valid != sel_ff) begin
                           cmd_a.op    = edra_pkg::CH_POP;
                           head_in     = front_track_a;
                           load_client = front_client_a;
                        end else begin
                           cmd_b.op    = edra_pkg::CH_POP;
                           head_in     = front_track_b;
                           load_client = front_client_b;
                        end
                        if (!sweep_valid) begin
                           sel_in = !sel_ff;
                        end
                     end else begin
                        busy_in     = 1'b0;
                        load_status = edra_pkg::ST_FREED;
                        load_client = '0;
                     end
                  end
                  edra_pkg::OP_EXPIRE: begin
                     state_in        = edra_pkg::CTL_PURGE;
                     purge_client_in = req_chan.requester;
                     removed_in      = 1'b0;
                  end
                  default: begin
                     load        = 1'b1;
                     load_status = edra_pkg::ST_IGNORED;
                  end
               endcase
            end
         end
         edra_pkg::CTL_PURGE: begin
            cmd_a.client = purge_client_ff;
            cmd_b.client = purge_client_ff;
            if (stat_a.any_match || stat_b.any_match) begin
               // drop the first match in each queue this cycle
               cmd_a.op   = edra_pkg::CH_PURGE;
               cmd_b.op   = edra_pkg::CH_PURGE;
               removed_in = 1'b1;
            end else if (slot_free) begin
               load        = 1'b1;
               load_status = removed_ff ? edra_pkg::ST_REMOVED : edra_pkg::ST_IGNORED;
               load_client = purge_client_ff;
               state_in    = edra_pkg::CTL_IDLE;
            end
         end
         default: begin
            state_in = edra_pkg::CTL_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_chan.ready);

   // Hold control state and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= edra_pkg::CTL_IDLE;
         busy_ff      <= 1'b0;
         head_ff      <= '0;
         sel_ff       <= 1'b0;
         removed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         head_ff      <= head_in;
         sel_ff       <= sel_in;
         removed_ff   <= removed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      purge_client_ff <= purge_client_in;
      if (load) begin
         rsp_status_ff <= load_status;
         rsp_client_ff <= load_client;
         rsp_head_ff   <= edra_pkg::TRACK_W'(head_in);
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.client     = rsp_client_ff;
   assign rsp_chan.head_track = rsp_head_ff;

endmodule

// File: design/edra_cell.sv
// One queue cell: holds a single pending request and shifts with its neighbours.
// Depends on edra_pkg for the chain command and link types.
module edra_cell #(
   parameter int TRACK_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  edra_pkg::chain_cmd_type       cmd,
   input  logic [TRACK_BITS-1:0]         new_track,
   input  edra_pkg::link_type            left_link,
   input  logic                          left_valid,
   input  logic                          left_expire,
   input  logic [edra_pkg::CLIENT_W-1:0] left_client,
   input  logic [TRACK_BITS-1:0]         left_track,
   input  logic                          right_valid,
   input  logic                          right_expire,
   input  logic [edra_pkg::CLIENT_W-1:0] right_client,
   input  logic [TRACK_BITS-1:0]         right_track,
   output edra_pkg::link_type            link,
   output logic                          valid,
   output logic                          expire,
   output logic [edra_pkg::CLIENT_W-1:0] client,
   output logic [TRACK_BITS-1:0]         track
);

   logic                          valid_ff,  valid_in;
   logic                          expire_ff, expire_in;
   logic [edra_pkg::CLIENT_W-1:0] client_ff, client_in;
   logic [TRACK_BITS-1:0]         track_ff,  track_in;
   logic                          match;

   // Work out the flags handed to the right-hand neighbour
   always_comb begin
      link.after = !(valid_ff && (track_ff <= new_track));
      match      = valid_ff && expire_ff && (client_ff == cmd.client);
      link.seen  = left_link.seen || match;
   end

   // Choose next contents: hold, take the new entry, or shift from a neighbour
   always_comb begin
      valid_in  = valid_ff;
      expire_in = expire_ff;
      client_in = client_ff;
      track_in  = track_ff;
      case (cmd.op)
         edra_pkg::CH_INSERT: begin
            if (link.after && left_link.after) begin
               valid_in  = left_valid;
               expire_in = left_expire;
               client_in = left_client;
               track_in  = left_track;
            end else if (link.after) begin
               valid_in  = 1'b1;
               expire_in = cmd.expire;
               client_in = cmd.client;
               track_in  = new_track;
            end
         end
         edra_pkg::CH_POP: begin
            valid_in  = right_valid;
            expire_in = right_expire;
            client_in = right_client;
            track_in  = right_track;
         end
         edra_pkg::CH_PURGE: begin
            if (link.seen) begin
               valid_in  = right_valid;
               expire_in = right_expire;
               client_in = right_client;
               track_in  = right_track;
            end
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   // Hold the cell contents
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      expire_ff <= expire_in;
      client_ff <= client_in;
      track_ff  <= track_in;
   end

   assign valid  = valid_ff;
   assign expire = expire_ff;
   assign client = client_ff;
   assign track  = track_ff;

endmodule

// File: design/edra_chain.sv
// Sorted queue built as a row of edra_cell instances, lowest track at the front.
// Depends on edra_pkg and edra_cell.
module edra_chain #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TRACK_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  edra_pkg::chain_cmd_type       cmd,
   input  logic [TRACK_BITS-1:0]         new_track,
   output edra_pkg::chain_status_type    status,
   output logic [edra_pkg::CLIENT_W-1:0] front_client,
   output logic [TRACK_BITS-1:0]         front_track
);

   edra_pkg::link_type            link   [QUEUE_DEPTH];
   logic                          valid  [QUEUE_DEPTH];
   logic                          expire [QUEUE_DEPTH];
   logic [edra_pkg::CLIENT_W-1:0] client [QUEUE_DEPTH];
   logic [TRACK_BITS-1:0]         track  [QUEUE_DEPTH];

   // Wire each cell to its left and right neighbours; the ends see an empty cell
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      edra_pkg::link_type            l_link;
      logic                          l_valid, l_expire, r_valid, r_expire;
      logic [edra_pkg::CLIENT_W-1:0] l_client, r_client;
      logic [TRACK_BITS-1:0]         l_track, r_track;

      if (i == 0) begin : g_first
         assign l_link   = '0;
         assign l_valid  = 1'b0;
         assign l_expire = 1'b0;
         assign l_client = '0;
         assign l_track  = '0;
      end else begin : g_inner_l
         assign l_link   = link[i-1];
         assign l_valid  = valid[i-1];
         assign l_expire = expire[i-1];
         assign l_client = client[i-1];
         assign l_track  = track[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign r_valid  = 1'b0;
         assign r_expire = 1'b0;
         assign r_client = '0;
         assign r_track  = '0;
      end else begin : g_inner_r
         assign r_valid  = valid[i+1];
         assign r_expire = expire[i+1];
         assign r_client = client[i+1];
         assign r_track  = track[i+1];
      end

      edra_cell #(
         .TRACK_BITS (TRACK_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .new_track    (new_track),
         .left_link    (l_link),
         .left_valid   (l_valid),
         .left_expire  (l_expire),
         .left_client  (l_client),
         .left_track   (l_track),
         .right_valid  (r_valid),
         .right_expire (r_expire),
         .right_client (r_client),
         .right_track  (r_track),
         .link         (link[i]),
         .valid        (valid[i]),
         .expire       (expire[i]),
         .client       (client[i]),
         .track        (track[i])
      );
   end

   // Report the front entry and whether any cell matches the purge client
   assign status.front_valid = valid[0];
   assign status.any_match   = link[QUEUE_DEPTH-1].seen;
   assign front_client       = client[0];
   assign front_track        = track[0];

endmodule

// File: design/edra_checker.sv
// Port-level checks for the disk arbiter, attached to the top level by bind.
// Depends on edra_pkg and on elevator_disk_request_arbiter.
module edra_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [edra_pkg::OP_W-1:0]     req_operation,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [edra_pkg::STATUS_W-1:0] rsp_status,
   input logic [edra_pkg::CLIENT_W-1:0] rsp_client,
   input logic [edra_pkg::TRACK_W-1:0]  rsp_head_track
);

   // A stalled result holds until transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_client) && $stable(rsp_head_track))
      else $error("result changed while stalled");

   // A freed disk reports no client
   a_freed_client: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == edra_pkg::ST_FREED |-> rsp_client == '0)
      else $error("disk freed with nonzero client");

   // A transferred request answers next cycle with granted or queued
   a_request_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == edra_pkg::OP_REQUEST |=>
         rsp_valid && (rsp_status == edra_pkg::ST_GRANTED ||
                       rsp_status == edra_pkg::ST_QUEUED))
      else $error("request gave wrong result");

   // A transferred release answers next cycle with a grant or a free
   a_release_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == edra_pkg::OP_RELEASE |=>
         rsp_valid && (rsp_status == edra_pkg::ST_WAITER ||
                       rsp_status == edra_pkg::ST_FREED))
      else $error("release gave wrong result");

endmodule

bind elevator_disk_request_arbiter edra_checker u_edra_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_operation  (req_chan.operation),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_client     (rsp_chan.client),
   .rsp_head_track (rsp_chan.head_track)
);
